// ===== src/dirty_rect_tracker_core_assert.svh =====
// assertion macros shared by the dirty rectangle tracker rtl
`ifndef DIRTY_RECT_TRACKER_CORE_ASSERT_SVH
`define DIRTY_RECT_TRACKER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define DRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define DRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/drt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package drt_pkg;

  localparam int unsigned CoordW  = 12;
  localparam int unsigned RegionW = 11;
  localparam int unsigned UnitW   = 13;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } box_t;

  typedef struct packed {
    logic               nonempty;
    logic [RegionW-1:0] x0;
    logic [RegionW-1:0] y0;
    logic [RegionW-1:0] x1;
    logic [RegionW-1:0] y1;
  } region_t;

  typedef struct packed {
    logic accept;
    logic ld1;
    logic ld2;
    logic ld3;
  } lane_ctrl_t;

  typedef struct packed {
    logic   eye_a_visible;
    coord_t eye_a_left;
    coord_t eye_a_top;
    coord_t eye_a_right;
    coord_t eye_a_bottom;
    logic   eye_b_visible;
    coord_t eye_b_left;
    coord_t eye_b_top;
    coord_t eye_b_right;
    coord_t eye_b_bottom;
  } in_t;

  typedef struct packed {
    logic [9:0]  region_left;
    logic [9:0]  region_top;
    logic [10:0] region_right;
    logic [10:0] region_bottom;
    logic        region_none;
    logic        region_last;
  } out_t;

endpackage

`default_nettype wire

// ===== src/drt_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module drt_lane #(
  parameter int unsigned SCREEN_WIDTH  = 466,
  parameter int unsigned SCREEN_HEIGHT = 466,
  parameter int unsigned GRID_SIZE     = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  drt_pkg::lane_ctrl_t ctrl_i,
  input  wire                 visible_i,
  input  drt_pkg::box_t       box_i,
  output drt_pkg::region_t    region_o
);

  localparam int unsigned CW       = drt_pkg::CoordW;
  localparam int unsigned UW       = drt_pkg::UnitW;
  localparam int unsigned RW       = drt_pkg::RegionW;
  localparam int unsigned GridBits = $clog2(GRID_SIZE);
  localparam int unsigned Half     = 1 << (CW - 1);
  // multiple of the grid that lifts every coordinate to a non-negative value
  localparam int unsigned Offset   = GRID_SIZE * ((Half + GRID_SIZE - 1) / GRID_SIZE);
  localparam int unsigned Shift    = UW + GridBits;
  localparam int unsigned Recip    = ((1 << Shift) + GRID_SIZE - 1) / GRID_SIZE;
  localparam int unsigned PW       = Shift + UW;
  localparam int unsigned SW       = UW + GridBits + 2;

  function automatic logic box_empty(drt_pkg::box_t b);
    return (b.x0 >= b.x1) || (b.y0 >= b.y1);
  endfunction

  drt_pkg::box_t   prev_q;
  drt_pkg::box_t   cur;
  drt_pkg::box_t   uni;
  drt_pkg::coord_t uni_c [4];

  logic [UW-1:0] u_d [4];
  logic [UW-1:0] u_q [4];
  logic          e1_q;
  logic [UW-1:0] q_d [4];
  logic [UW-1:0] q_q [4];
  logic          e2_q;
  logic signed [SW-1:0] clip [4];
  drt_pkg::region_t region_d;
  drt_pkg::region_t region_q;

  // union of the stored box and the current one
  always_comb begin
    cur = visible_i ? box_i : '0;
    if (box_empty(prev_q)) begin
      uni = cur;
    end else if (box_empty(cur)) begin
      uni = prev_q;
    end else begin
      uni.x0 = (prev_q.x0 < cur.x0) ? prev_q.x0 : cur.x0;
      uni.y0 = (prev_q.y0 < cur.y0) ? prev_q.y0 : cur.y0;
      uni.x1 = (prev_q.x1 > cur.x1) ? prev_q.x1 : cur.x1;
      uni.y1 = (prev_q.y1 > cur.y1) ? prev_q.y1 : cur.y1;
    end
    uni_c[0] = uni.x0;
    uni_c[1] = uni.y0;
    uni_c[2] = uni.x1;
    uni_c[3] = uni.y1;
  end

  // ends get grid-1 added so that one floor serves both
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (k < 2) begin
        u_d[k] = {{(UW-CW){uni_c[k][CW-1]}}, uni_c[k]} + UW'(Offset);
      end else begin
        u_d[k] = {{(UW-CW){uni_c[k][CW-1]}}, uni_c[k]} + UW'(Offset + GRID_SIZE - 1);
      end
    end
  end

  // quotient by reciprocal, exact over the whole lifted range
  always_comb begin
    logic [PW-1:0] prod;
    prod = '0;
    for (int k = 0; k < 4; k++) begin
      prod   = PW'(u_q[k]) * PW'(Recip);
      q_d[k] = prod[Shift +: UW];
    end
  end

  always_comb begin
    logic signed [SW-1:0] snap;
    snap = '0;
    for (int k = 0; k < 4; k++) begin
      snap = $signed(SW'(q_q[k]) * SW'(GRID_SIZE) - SW'(Offset));
      if (k < 2) begin
        clip[k] = (snap < 0) ? '0 : snap;
      end else if (k == 2) begin
        clip[k] = (snap > $signed(SW'(SCREEN_WIDTH))) ? $signed(SW'(SCREEN_WIDTH)) : snap;
      end else begin
        clip[k] = (snap > $signed(SW'(SCREEN_HEIGHT))) ? $signed(SW'(SCREEN_HEIGHT)) : snap;
      end
    end
    region_d.nonempty = !e2_q && (clip[0] < clip[2]) && (clip[1] < clip[3]);
    region_d.x0       = clip[0][RW-1:0];
    region_d.y0       = clip[1][RW-1:0];
    region_d.x1       = clip[2][RW-1:0];
    region_d.y1       = clip[3][RW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (ctrl_i.accept) begin
      prev_q <= cur;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld1) begin
      u_q  <= u_d;
      e1_q <= box_empty(uni);
    end
    if (ctrl_i.ld2) begin
      q_q  <= q_d;
      e2_q <= e1_q;
    end
    if (ctrl_i.ld3) begin
      region_q <= region_d;
    end
  end

  assign region_o = region_q;

endmodule

`default_nettype wire

// ===== src/drt_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module drt_merge (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  drt_pkg::region_t region_a_i,
  input  drt_pkg::region_t region_b_i,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  output drt_pkg::out_t    out_data_o
);

  function automatic drt_pkg::out_t to_out(drt_pkg::region_t r, logic last);
    drt_pkg::out_t o;
    o.region_left   = r.x0[9:0];
    o.region_top    = r.y0[9:0];
    o.region_right  = r.x1;
    o.region_bottom = r.y1;
    o.region_none   = 1'b0;
    o.region_last   = last;
    return o;
  endfunction

  logic          v_q;
  logic          two_q;
  logic          two_d;
  logic          idx_q;
  logic          last;
  logic          overlap;
  drt_pkg::region_t uni;
  drt_pkg::out_t r0_q;
  drt_pkg::out_t r1_q;
  drt_pkg::out_t r0_d;
  drt_pkg::out_t r1_d;

  assign last       = idx_q || !two_q;
  assign in_ready_o = !v_q || (!out_stall_i && last);

  always_comb begin
    overlap = region_a_i.nonempty && region_b_i.nonempty &&
              (region_a_i.x0 < region_b_i.x1) && (region_b_i.x0 < region_a_i.x1) &&
              (region_a_i.y0 < region_b_i.y1) && (region_b_i.y0 < region_a_i.y1);
    uni.nonempty = 1'b1;
    uni.x0 = (region_a_i.x0 < region_b_i.x0) ? region_a_i.x0 : region_b_i.x0;
    uni.y0 = (region_a_i.y0 < region_b_i.y0) ? region_a_i.y0 : region_b_i.y0;
    uni.x1 = (region_a_i.x1 > region_b_i.x1) ? region_a_i.x1 : region_b_i.x1;
    uni.y1 = (region_a_i.y1 > region_b_i.y1) ? region_a_i.y1 : region_b_i.y1;

    two_d = 1'b0;
    r1_d  = to_out(region_b_i, 1'b1);
    if (overlap) begin
      r0_d = to_out(uni, 1'b1);
    end else if (region_a_i.nonempty && region_b_i.nonempty) begin
      r0_d  = to_out(region_a_i, 1'b0);
      two_d = 1'b1;
    end else if (region_a_i.nonempty) begin
      r0_d = to_out(region_a_i, 1'b1);
    end else if (region_b_i.nonempty) begin
      r0_d = to_out(region_b_i, 1'b1);
    end else begin
      // nothing dirty: single marker with zero coordinates
      r0_d             = '0;
      r0_d.region_none = 1'b1;
      r0_d.region_last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= 1'b0;
      two_q <= 1'b0;
      idx_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q   <= in_valid_i;
      two_q <= two_d;
      idx_q <= 1'b0;
    end else if (v_q && !out_stall_i) begin
      idx_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      r0_q <= r0_d;
      r1_q <= r1_d;
    end
  end

  assign out_valid_o = v_q;
  assign out_data_o  = idx_q ? r1_q : r0_q;

endmodule

`default_nettype wire

// ===== src/dirty_rect_tracker_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "dirty_rect_tracker_core_assert.svh"

// Dirty rectangle tracker. Each request carries the boxes of two objects for one
// frame; two identical lanes unite each box with that object's box of the
// previous frame, snap the union outward to the grid and clip it to the screen,
// and a merge stage drops empty regions, joins overlapping ones and queues the
// results. A new request is taken every cycle while the output side keeps up;
// each request yields one or two results and the output port sends one result
// per cycle while out_stall_i is low, so a request with two results holds off
// further requests until its second result is sent. The first result of a
// request passes through the lifted union, registered when the request is
// taken, then reciprocal multiply, grid multiply and clip, and merge. There is
// no clearing pass after reset.
module dirty_rect_tracker_core #(
  parameter int unsigned SCREEN_WIDTH  = 466,
  parameter int unsigned SCREEN_HEIGHT = 466,
  parameter int unsigned GRID_SIZE     = 16
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           in_valid_i,
  output logic          in_stall_o,
  input  drt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  wire           out_stall_i,
  output drt_pkg::out_t out_data_o
);

  logic v1_q;
  logic v2_q;
  logic v3_q;
  logic rdy1;
  logic rdy2;
  logic rdy3;
  logic rdy4;

  drt_pkg::lane_ctrl_t ctrl;
  drt_pkg::box_t       box_a;
  drt_pkg::box_t       box_b;
  drt_pkg::region_t    region_a;
  drt_pkg::region_t    region_b;

  // a stage takes new data when it is empty or its content moves on
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_stall_o  = !rdy1;
  assign ctrl.accept = in_valid_i && rdy1;
  assign ctrl.ld1    = rdy1;
  assign ctrl.ld2    = rdy2;
  assign ctrl.ld3    = rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  assign box_a.x0 = in_data_i.eye_a_left;
  assign box_a.y0 = in_data_i.eye_a_top;
  assign box_a.x1 = in_data_i.eye_a_right;
  assign box_a.y1 = in_data_i.eye_a_bottom;
  assign box_b.x0 = in_data_i.eye_b_left;
  assign box_b.y0 = in_data_i.eye_b_top;
  assign box_b.x1 = in_data_i.eye_b_right;
  assign box_b.y1 = in_data_i.eye_b_bottom;

  drt_lane #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .GRID_SIZE    (GRID_SIZE)
  ) u_lane_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .visible_i(in_data_i.eye_a_visible),
    .box_i    (box_a),
    .region_o (region_a)
  );

  drt_lane #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .GRID_SIZE    (GRID_SIZE)
  ) u_lane_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .visible_i(in_data_i.eye_b_visible),
    .box_i    (box_b),
    .region_o (region_b)
  );

  drt_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (v3_q),
    .in_ready_o (rdy4),
    .region_a_i (region_a),
    .region_b_i (region_b),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  `DRT_ASSERT_NOW(a_none_is_last, out_valid_o && out_data_o.region_none,
                  out_data_o.region_last, "none marker without last flag")
  `DRT_ASSERT_NOW(a_none_is_zero, out_valid_o && out_data_o.region_none,
                  out_data_o.region_left == 0 && out_data_o.region_top == 0 &&
                  out_data_o.region_right == 0 && out_data_o.region_bottom == 0,
                  "none marker with nonzero coordinates")
  `DRT_ASSERT_NOW(a_region_nonempty, out_valid_o && !out_data_o.region_none,
                  out_data_o.region_left < out_data_o.region_right &&
                  out_data_o.region_top < out_data_o.region_bottom,
                  "empty region sent")
  `DRT_ASSERT_NOW(a_region_on_screen, out_valid_o && !out_data_o.region_none,
                  out_data_o.region_right <= SCREEN_WIDTH &&
                  out_data_o.region_bottom <= SCREEN_HEIGHT,
                  "region not clipped to screen")
  `DRT_ASSERT_NEXT(a_second_follows,
                   out_valid_o && !out_stall_i && !out_data_o.region_last,
                   out_valid_o && out_data_o.region_last && !out_data_o.region_none,
                   "second region of a request missing")

endmodule

`default_nettype wire
